// ===== rtl/wes_pkg.sv =====
// Shared constants and types for the wheel encoder speed estimator.
package wes_pkg;

   localparam int TICK_WIDTH_DEF      = 32;
   localparam int SPEED_FRAC_BITS_DEF = 16;

   localparam int TPM_W    = 16;
   localparam int SECS_W   = 32;
   localparam int NSECS_W  = 30;
   localparam int SPEED_W  = 32;

   localparam logic [TPM_W-1:0]   TPM_RESET  = 16'd1000;
   localparam logic [NSECS_W-1:0] NS_PER_SEC = 30'd1000000000;

   // elapsed seconds: signed, magnitude up to 2^32 + 1
   localparam int ELAP_W = 35;
   localparam int EMAG_W = 34;
   localparam int DEN_W  = TPM_W + EMAG_W;

   // normalized time: 33-bit seconds above 30-bit nanoseconds
   localparam int TIME_W = SECS_W + 1 + NSECS_W;

   localparam int REQ_DATA_W = 96;
   localparam int RSP_DATA_W = 96;
   localparam int RSP_USER_W = 2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIFF,
      ST_ELAP,
      ST_ABS,
      ST_MUL,
      ST_DIV,
      ST_SAT,
      ST_NORM,
      ST_OUT
   } wes_state_type;

endpackage

// ===== rtl/wes_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
module wes_div #(
   parameter int NUM_W = 48,
   parameter int DEN_W = 50
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quo
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [DEN_W:0]   shifted;
   logic [DEN_W:0]   trial;
   logic             fits;

   assign shifted = {rem_ff, quo_ff[NUM_W-1]};
   assign fits    = shifted >= {1'b0, den_ff};
   assign trial   = shifted - {1'b0, den_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = num;
         rem_in  = '0;
         den_in  = den;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
         quo_in = {quo_ff[NUM_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

// ===== rtl/wheel_encoder_speed_estimator.sv =====
// A speed update passes ST_DIFF, ST_ELAP, ST_ABS and ST_MUL, waits in ST_DIV for the
// bit-serial divider, then passes ST_SAT, ST_NORM and ST_OUT; a first sample goes from
// ST_DIFF to ST_NORM, and an error leaves ST_ABS for ST_NORM. One transaction is handled
// at a time; the next is taken only after the result is in the output register, and a
// result still waiting there holds the block in ST_OUT until the result side takes it.
// Reset (synchronous): clears wheel history, speeds and flags; the tick scale returns to 1000.
module wheel_encoder_speed_estimator #(
   parameter int TICK_WIDTH      = wes_pkg::TICK_WIDTH_DEF,
   parameter int SPEED_FRAC_BITS = wes_pkg::SPEED_FRAC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // tdata: tick[31:0], stamp_secs[63:32], stamp_nsecs[93:64], zero[95:94]
   input  logic [wes_pkg::REQ_DATA_W-1:0]  req_tdata,
   // tuser: wheel[0]
   input  logic                            req_tuser,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // tdata: speed[31:0], out_secs[63:32], out_nsecs[93:64], zero[95:94]
   output logic [wes_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // tuser: speed_valid[0], sample_error[1]
   output logic [wes_pkg::RSP_USER_W-1:0]  rsp_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic                            csr_wr_en,
   input  logic [wes_pkg::TPM_W-1:0]       csr_wr_data
);

   import wes_pkg::*;

   localparam int TW    = TICK_WIDTH;
   localparam int NUM_W = TICK_WIDTH + SPEED_FRAC_BITS;
   localparam int QX_W  = (NUM_W > SPEED_W) ? NUM_W : SPEED_W + 1;

   localparam logic signed [NSECS_W:0]  DN_SEC   = $signed({1'b0, NS_PER_SEC});
   localparam logic signed [ELAP_W-1:0] ELAP_ONE = ELAP_W'(1);
   localparam logic [QX_W-1:0]          Q_POS_MAX = QX_W'(32'h7FFF_FFFF);
   localparam logic [QX_W-1:0]          Q_NEG_MAX = QX_W'(32'h8000_0000);

   wes_state_type state_ff, state_in;

   logic [TPM_W-1:0]   tpm_ff, tpm_in;

   // captured transaction
   logic               wheel_ff, wheel_in;
   logic [TW-1:0]      tick_ff, tick_in;
   logic [SECS_W-1:0]  secs_ff, secs_in;
   logic [NSECS_W-1:0] nsecs_ff, nsecs_in;

   // per-wheel history
   logic               l_seen_ff, l_seen_in, r_seen_ff, r_seen_in;
   logic [TW-1:0]      l_tick_ff, l_tick_in, r_tick_ff, r_tick_in;
   logic [SECS_W-1:0]  l_secs_ff, l_secs_in, r_secs_ff, r_secs_in;
   logic [NSECS_W-1:0] l_nsecs_ff, l_nsecs_in, r_nsecs_ff, r_nsecs_in;
   logic [SPEED_W-1:0] l_speed_ff, l_speed_in, r_speed_ff, r_speed_in;
   logic               l_sv_ff, l_sv_in, r_sv_ff, r_sv_in;

   // working registers
   logic [TW-1:0]             absdiff_ff, absdiff_in;
   logic                      dneg_ff, dneg_in;
   logic signed [SECS_W:0]    ds_ff, ds_in;
   logic signed [NSECS_W:0]   dn_ff, dn_in;
   logic signed [ELAP_W-1:0]  elap_ff, elap_in;
   logic [EMAG_W-1:0]         emag_ff, emag_in;
   logic                      neg_ff, neg_in;
   logic                      err_ff, err_in;
   logic [TIME_W-1:0]         lt_ff, lt_in, rt_ff, rt_in;
   logic [SPEED_W-1:0]        avg_ff, avg_in;

   logic                      rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_DATA_W-1:0]     rsp_tdata_ff, rsp_tdata_in;
   logic [RSP_USER_W-1:0]     rsp_tuser_ff, rsp_tuser_in;

   // combinational helpers
   logic                      sel_seen;
   logic [TW-1:0]             sel_tick;
   logic [SECS_W-1:0]         sel_secs;
   logic [NSECS_W-1:0]        sel_nsecs;
   logic [TW-1:0]             tick_d;
   logic signed [2:0]         fl;
   logic                      exact;
   logic signed [ELAP_W-1:0]  elap_q;
   logic [SECS_W:0]           spd_sum;
   logic [TIME_W-1:0]         later;
   logic [QX_W-1:0]           q_x;
   logic [SPEED_W-1:0]        spd_sat;
   logic                      both_valid;

   logic                      div_start;
   logic                      div_done;
   logic [NUM_W-1:0]          div_num;
   logic [DEN_W-1:0]          div_den;
   logic [NUM_W-1:0]          div_quo;

   function automatic logic [TIME_W-1:0] norm_time(input logic [SECS_W-1:0]  s,
                                                   input logic [NSECS_W-1:0] n);
      logic [SECS_W:0] s_x;
      s_x = {1'b0, s};
      if (n >= NS_PER_SEC) begin
         return {s_x + (SECS_W+1)'(1), n - NS_PER_SEC};
      end
      return {s_x, n};
   endfunction

   assign div_num = {absdiff_ff, {SPEED_FRAC_BITS{1'b0}}};
   assign div_den = tpm_ff * emag_ff;

   wes_div #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   assign sel_seen  = wheel_ff ? r_seen_ff  : l_seen_ff;
   assign sel_tick  = wheel_ff ? r_tick_ff  : l_tick_ff;
   assign sel_secs  = wheel_ff ? r_secs_ff  : l_secs_ff;
   assign sel_nsecs = wheel_ff ? r_nsecs_ff : l_nsecs_ff;
   assign tick_d    = tick_ff - sel_tick;

   // split the nanosecond difference into whole seconds and an exact-multiple flag
   always_comb begin
      if (dn_ff >= DN_SEC) begin
         fl = 3'sd1;
      end else if (dn_ff >= 0) begin
         fl = 3'sd0;
      end else if (dn_ff >= -DN_SEC) begin
         fl = -3'sd1;
      end else begin
         fl = -3'sd2;
      end
   end

   assign exact  = (dn_ff == 0) || (dn_ff == DN_SEC) || (dn_ff == -DN_SEC);
   assign elap_q = ELAP_W'(ds_ff) + ELAP_W'(fl);

   assign q_x = QX_W'(div_quo);
   always_comb begin
      if (neg_ff) begin
         spd_sat = (q_x >= Q_NEG_MAX) ? 32'h8000_0000 : (32'd0 - q_x[SPEED_W-1:0]);
      end else begin
         spd_sat = (q_x > Q_POS_MAX) ? 32'h7FFF_FFFF : q_x[SPEED_W-1:0];
      end
   end

   assign spd_sum    = {l_speed_ff[SPEED_W-1], l_speed_ff} + {r_speed_ff[SPEED_W-1], r_speed_ff};
   assign later      = (lt_ff > rt_ff) ? lt_ff : rt_ff;
   assign both_valid = l_sv_ff && r_sv_ff;

   always_comb begin
      state_in      = state_ff;
      tpm_in        = csr_wr_en ? csr_wr_data : tpm_ff;
      wheel_in      = wheel_ff;
      tick_in       = tick_ff;
      secs_in       = secs_ff;
      nsecs_in      = nsecs_ff;
      l_seen_in     = l_seen_ff;
      r_seen_in     = r_seen_ff;
      l_tick_in     = l_tick_ff;
      r_tick_in     = r_tick_ff;
      l_secs_in     = l_secs_ff;
      r_secs_in     = r_secs_ff;
      l_nsecs_in    = l_nsecs_ff;
      r_nsecs_in    = r_nsecs_ff;
      l_speed_in    = l_speed_ff;
      r_speed_in    = r_speed_ff;
      l_sv_in       = l_sv_ff;
      r_sv_in       = r_sv_ff;
      absdiff_in    = absdiff_ff;
      dneg_in       = dneg_ff;
      ds_in         = ds_ff;
      dn_in         = dn_ff;
      elap_in       = elap_ff;
      emag_in       = emag_ff;
      neg_in        = neg_ff;
      err_in        = err_ff;
      lt_in         = lt_ff;
      rt_in         = rt_ff;
      avg_in        = avg_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      req_tready    = 1'b0;
      div_start     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               wheel_in = req_tuser;
               tick_in  = req_tdata[TW-1:0];
               secs_in  = req_tdata[63:32];
               nsecs_in = req_tdata[93:64];
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            // store the new sample; the old one is consumed this cycle
            if (wheel_ff) begin
               r_seen_in  = 1'b1;
               r_tick_in  = tick_ff;
               r_secs_in  = secs_ff;
               r_nsecs_in = nsecs_ff;
            end else begin
               l_seen_in  = 1'b1;
               l_tick_in  = tick_ff;
               l_secs_in  = secs_ff;
               l_nsecs_in = nsecs_ff;
            end
            err_in     = 1'b0;
            dneg_in    = tick_d[TW-1];
            absdiff_in = tick_d[TW-1] ? (TW'(0) - tick_d) : tick_d;
            ds_in      = $signed({1'b0, secs_ff}) - $signed({1'b0, sel_secs});
            dn_in      = $signed({1'b0, nsecs_ff}) - $signed({1'b0, sel_nsecs});
            state_in   = sel_seen ? ST_ELAP : ST_NORM;
         end
         ST_ELAP: begin
            // truncate toward zero
            elap_in  = (elap_q[ELAP_W-1] && !exact) ? (elap_q + ELAP_ONE) : elap_q;
            state_in = ST_ABS;
         end
         ST_ABS: begin
            if ((elap_ff == 0) || (tpm_ff == '0)) begin
               err_in   = 1'b1;
               state_in = ST_NORM;
            end else begin
               emag_in  = elap_ff[ELAP_W-1] ? EMAG_W'(-elap_ff) : EMAG_W'(elap_ff);
               neg_in   = dneg_ff ^ elap_ff[ELAP_W-1];
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            div_start = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_SAT;
            end
         end
         ST_SAT: begin
            if (wheel_ff) begin
               r_speed_in = spd_sat;
               r_sv_in    = 1'b1;
            end else begin
               l_speed_in = spd_sat;
               l_sv_in    = 1'b1;
            end
            state_in = ST_NORM;
         end
         ST_NORM: begin
            lt_in    = norm_time(l_secs_ff, l_nsecs_ff);
            rt_in    = norm_time(r_secs_ff, r_nsecs_ff);
            avg_in   = spd_sum[SPEED_W:1];
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // hold until the output register is free
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {2'b00, later[NSECS_W-1:0], later[NSECS_W+SECS_W-1:NSECS_W],
                                (both_valid ? avg_ff : '0)};
               rsp_tuser_in  = {err_ff, both_valid};
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         tpm_ff        <= TPM_RESET;
         l_seen_ff     <= 1'b0;
         r_seen_ff     <= 1'b0;
         l_secs_ff     <= '0;
         r_secs_ff     <= '0;
         l_nsecs_ff    <= '0;
         r_nsecs_ff    <= '0;
         l_speed_ff    <= '0;
         r_speed_ff    <= '0;
         l_sv_ff       <= 1'b0;
         r_sv_ff       <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         tpm_ff        <= tpm_in;
         l_seen_ff     <= l_seen_in;
         r_seen_ff     <= r_seen_in;
         l_secs_ff     <= l_secs_in;
         r_secs_ff     <= r_secs_in;
         l_nsecs_ff    <= l_nsecs_in;
         r_nsecs_ff    <= r_nsecs_in;
         l_speed_ff    <= l_speed_in;
         r_speed_ff    <= r_speed_in;
         l_sv_ff       <= l_sv_in;
         r_sv_ff       <= r_sv_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      wheel_ff     <= wheel_in;
      tick_ff      <= tick_in;
      secs_ff      <= secs_in;
      nsecs_ff     <= nsecs_in;
      l_tick_ff    <= l_tick_in;
      r_tick_ff    <= r_tick_in;
      absdiff_ff   <= absdiff_in;
      dneg_ff      <= dneg_in;
      ds_ff        <= ds_in;
      dn_ff        <= dn_in;
      elap_ff      <= elap_in;
      emag_ff      <= emag_in;
      neg_ff       <= neg_in;
      err_ff       <= err_in;
      lt_ff        <= lt_in;
      rt_ff        <= rt_in;
      avg_ff       <= avg_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule
